### src/clm_pkg.sv
// Shared types and constants of the core load meter.
// Used by the channel interfaces and by cpu_load_meter; depends on nothing.
package clm_pkg;

	// Field widths of the event and report beats.
	localparam int KIND_W  = 2;
	localparam int FIELD_W = 32;
	localparam int LOAD_W  = 8;

	// Width at which cycle stamps are stored and differenced.
	localparam int STAMP_W = 32;

	// Load division: numerator work*100, divisor work+sleep without wrap.
	localparam int QUO_W  = 7;
	localparam int NUM_W  = FIELD_W + QUO_W;
	localparam int DEN_W  = FIELD_W + 1;
	localparam int STEP_W = $clog2(QUO_W);

	// Operand width of the shared add/subtract unit.
	localparam int OPW = (NUM_W > STAMP_W) ? NUM_W : STAMP_W;

	// Event kinds; the fourth code is ignored.
	localparam logic [KIND_W-1:0] KIND_SLEEP  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WAKE   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;

	// Load codes.
	localparam logic [LOAD_W-1:0] FULL_LOAD = 8'd100;
	localparam logic [LOAD_W-1:0] NO_LOAD   = 8'd255;

endpackage

### src/clm_evt_if.sv
// Event channel of the core load meter: valid/ready plus kind and stamp.
// Depends on clm_pkg for the field widths.
interface clm_evt_if;
	logic                             valid;
	logic                             ready;
	logic [clm_pkg::KIND_W-1:0]       kind;
	logic [clm_pkg::FIELD_W-1:0]      cycle_stamp;

	modport source (output valid, kind, cycle_stamp, input ready);
	modport sink   (input valid, kind, cycle_stamp, output ready);
endinterface

### src/clm_rpt_if.sv
// Report channel of the core load meter: valid/ready plus totals and load.
// Depends on clm_pkg for the field widths.
interface clm_rpt_if;
	logic                             valid;
	logic                             ready;
	logic [clm_pkg::FIELD_W-1:0]      sleep_cycles;
	logic [clm_pkg::FIELD_W-1:0]      work_cycles;
	logic [clm_pkg::FIELD_W-1:0]      sleep_events;
	logic [clm_pkg::LOAD_W-1:0]       load_percent;

	modport source (output valid, sleep_cycles, work_cycles, sleep_events, load_percent,
		input ready);
	modport sink   (input valid, sleep_cycles, work_cycles, sleep_events, load_percent,
		output ready);
endinterface

### src/cpu_load_meter.sv
// Core load meter: accumulates work and sleep cycles from stamped events.
// Depends on clm_pkg, clm_evt_if and clm_rpt_if.
//
//  channel | dir | fields                                              | beat
//  evt     | in  | kind, cycle_stamp                                   | one event
//  rpt     | out | sleep_cycles, work_cycles, sleep_events, load_percent | one report
//
// A sleep event, or a wake event while asleep, runs through accept, stamp
// difference and total update, the last two on one shared add/subtract unit.
// Other wake events and the unused kind end with their accept.
// A report that divides runs through accept, a multiply-and-sum step,
// 7 restoring division steps on the shared unit, and a load into the output
// register. A report with an empty sleep total skips the division.
// A report waits in its last cycle while a previous report beat is not taken;
// events are accepted while a finished report waits on rpt.
// arst_n clears all totals and stamps and marks the core awake.
module cpu_load_meter (
	input  logic          clk,
	input  logic          arst_n,
	clm_evt_if.sink       evt,
	clm_rpt_if.source     rpt
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SPAN,
		ST_ACCUM,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                         state_q;
	logic [clm_pkg::KIND_W-1:0]     kind_q;
	logic [clm_pkg::STAMP_W-1:0]    stamp_q;
	logic [clm_pkg::STAMP_W-1:0]    work_start_q;
	logic [clm_pkg::STAMP_W-1:0]    sleep_start_q;
	logic [clm_pkg::FIELD_W-1:0]    work_total_q;
	logic [clm_pkg::FIELD_W-1:0]    sleep_total_q;
	logic [clm_pkg::FIELD_W-1:0]    sleep_tally_q;
	logic                           awake_q;
	logic [clm_pkg::FIELD_W-1:0]    diff_q;
	logic [clm_pkg::NUM_W-1:0]      rem_q;
	logic [clm_pkg::DEN_W-1:0]      den_q;
	logic [clm_pkg::STEP_W-1:0]     step_q;
	logic [clm_pkg::LOAD_W-1:0]     quo_q;

	logic                           rpt_vld_q;
	logic [clm_pkg::FIELD_W-1:0]    rpt_sleep_q;
	logic [clm_pkg::FIELD_W-1:0]    rpt_work_q;
	logic [clm_pkg::FIELD_W-1:0]    rpt_events_q;
	logic [clm_pkg::LOAD_W-1:0]     rpt_load_q;

	logic                           evt_acc;
	logic                           is_sleep;
	logic                           rpt_take;
	logic [clm_pkg::OPW-1:0]        alu_a;
	logic [clm_pkg::OPW-1:0]        alu_b;
	logic                           alu_sub;
	logic [clm_pkg::OPW:0]          alu_res;
	logic                           alu_borrow;
	logic [clm_pkg::NUM_W-1:0]      den_shift;
	logic [clm_pkg::NUM_W-1:0]      mul_res;

	assign evt.ready = (state_q == ST_IDLE);
	assign evt_acc   = evt.valid && evt.ready;
	assign is_sleep  = (kind_q == clm_pkg::KIND_SLEEP);

	// A finished report moves into the output register once it is free.
	assign rpt_take  = (state_q == ST_DONE) && (!rpt_vld_q || rpt.ready);

	// Divisor aligned to the current quotient bit.
	assign den_shift = clm_pkg::NUM_W'(den_q) << step_q;

	// Work total times one hundred, registered before the division.
	assign mul_res = clm_pkg::NUM_W'(work_total_q) * clm_pkg::NUM_W'(clm_pkg::FULL_LOAD);

	// Operand selection for the shared add/subtract unit.
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			ST_SPAN: begin
				alu_a   = clm_pkg::OPW'(stamp_q);
				alu_b   = is_sleep ? clm_pkg::OPW'(work_start_q) : clm_pkg::OPW'(sleep_start_q);
				alu_sub = 1'b1;
			end
			ST_ACCUM: begin
				alu_a = clm_pkg::OPW'(diff_q);
				alu_b = is_sleep ? clm_pkg::OPW'(work_total_q) : clm_pkg::OPW'(sleep_total_q);
			end
			ST_PREP: begin
				alu_a = clm_pkg::OPW'(work_total_q);
				alu_b = clm_pkg::OPW'(sleep_total_q);
			end
			ST_DIV: begin
				alu_a   = clm_pkg::OPW'(rem_q);
				alu_b   = clm_pkg::OPW'(den_shift);
				alu_sub = 1'b1;
			end
			default: begin
				alu_sub = 1'b0;
			end
		endcase
	end

	// The shared unit; the top bit is the carry or, when subtracting, the borrow.
	assign alu_res    = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
	                            : ({1'b0, alu_a} + {1'b0, alu_b});
	assign alu_borrow = alu_res[clm_pkg::OPW];

	// Sequencer, state registers and the report output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			kind_q        <= clm_pkg::KIND_SLEEP;
			stamp_q       <= '0;
			work_start_q  <= '0;
			sleep_start_q <= '0;
			work_total_q  <= '0;
			sleep_total_q <= '0;
			sleep_tally_q <= '0;
			awake_q       <= 1'b1;
			diff_q        <= '0;
			rem_q         <= '0;
			den_q         <= '0;
			step_q        <= '0;
			quo_q         <= '0;
			rpt_vld_q     <= 1'b0;
			rpt_sleep_q   <= '0;
			rpt_work_q    <= '0;
			rpt_events_q  <= '0;
			rpt_load_q    <= '0;
		end else begin
			// The output beat is held until taken and refilled in the same cycle.
			if (rpt_take) begin
				rpt_vld_q <= 1'b1;
			end else if (rpt.ready) begin
				rpt_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (evt_acc) begin
						kind_q  <= evt.kind;
						stamp_q <= clm_pkg::STAMP_W'(evt.cycle_stamp);
						case (evt.kind)
							clm_pkg::KIND_SLEEP:  state_q <= ST_SPAN;
							clm_pkg::KIND_WAKE:   state_q <= awake_q ? ST_IDLE : ST_SPAN;
							clm_pkg::KIND_REPORT: state_q <= ST_PREP;
							default:              state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SPAN: begin
					diff_q  <= clm_pkg::FIELD_W'(alu_res[clm_pkg::STAMP_W-1:0]);
					state_q <= ST_ACCUM;
				end
				ST_ACCUM: begin
					if (is_sleep) begin
						work_total_q  <= alu_res[clm_pkg::FIELD_W-1:0];
						sleep_tally_q <= sleep_tally_q + clm_pkg::FIELD_W'(1);
						sleep_start_q <= stamp_q;
						awake_q       <= 1'b0;
					end else begin
						sleep_total_q <= alu_res[clm_pkg::FIELD_W-1:0];
						work_start_q  <= stamp_q;
						awake_q       <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_PREP: begin
					// Both totals zero and sleep total zero need no division.
					rem_q  <= mul_res;
					den_q  <= alu_res[clm_pkg::DEN_W-1:0];
					step_q <= clm_pkg::STEP_W'(clm_pkg::QUO_W - 1);
					if (sleep_total_q == '0 && work_total_q == '0) begin
						quo_q   <= clm_pkg::NO_LOAD;
						awake_q <= 1'b1;
						state_q <= ST_DONE;
					end else if (sleep_total_q == '0) begin
						quo_q   <= clm_pkg::FULL_LOAD;
						state_q <= ST_DONE;
					end else begin
						quo_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					// One restoring step per cycle, most significant bit first.
					if (!alu_borrow) begin
						rem_q         <= alu_res[clm_pkg::NUM_W-1:0];
						quo_q[step_q] <= 1'b1;
					end
					if (step_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q - clm_pkg::STEP_W'(1);
					end
				end
				ST_DONE: begin
					// Hand over the totals once the output register is free.
					if (rpt_take) begin
						rpt_sleep_q   <= sleep_total_q;
						rpt_work_q    <= work_total_q;
						rpt_events_q  <= sleep_tally_q;
						rpt_load_q    <= quo_q;
						sleep_total_q <= '0;
						work_total_q  <= '0;
						sleep_tally_q <= '0;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rpt.valid        = rpt_vld_q;
	assign rpt.sleep_cycles = rpt_sleep_q;
	assign rpt.work_cycles  = rpt_work_q;
	assign rpt.sleep_events = rpt_events_q;
	assign rpt.load_percent = rpt_load_q;

	// A delivered load is a percentage or the no-cycles code.
	a_load_range: assert property (@(posedge clk) disable iff (!arst_n)
		rpt.valid |-> (rpt.load_percent <= clm_pkg::FULL_LOAD ||
			rpt.load_percent == clm_pkg::NO_LOAD))
		else $error("load_percent out of range");

	// The no-cycles code only comes with two empty totals.
	a_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		(rpt.valid && rpt.load_percent == clm_pkg::NO_LOAD) |->
		(rpt.sleep_cycles == '0 && rpt.work_cycles == '0))
		else $error("no-cycles code with nonzero totals");

	// The core only goes to sleep through the update of a sleep event.
	a_sleep_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(awake_q) |-> $past(state_q == ST_ACCUM && kind_q == clm_pkg::KIND_SLEEP))
		else $error("awake cleared outside a sleep event");

	// An accepted report always starts the load computation.
	a_report_start: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_acc && evt.kind == clm_pkg::KIND_REPORT) |=> (state_q == ST_PREP))
		else $error("report did not start the load computation");

endmodule
